// ===== design/nlp_pkg.sv =====
`timescale 1ns / 1ps
package nlp_pkg;

    // Default sizing
    localparam int NLP_RANGE_WIDTH   = 32;
    localparam int NLP_BINARY_DIGITS = 16;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_EMPTY      = 3'd1;
    localparam t_status ST_NO_DIGITS  = 3'd2;
    localparam t_status ST_RANGE      = 3'd3;
    localparam t_status ST_BIN_LENGTH = 3'd4;
    localparam t_status ST_BIN_DIGIT  = 3'd5;

    // ASCII codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    // Integer scanner view after the current character
    typedef struct packed {
        logic        digit;
        logic        over;
        logic [15:0] value;
    } t_int_res;

endpackage

// ===== design/nlp_if.sv =====
`timescale 1ns / 1ps
interface nlp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_token;

    modport source (output valid, output char_code, output last_char, output empty_token,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input empty_token,
                    output ready);
endinterface

interface nlp_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic [2:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== design/nlp_int_scan.sv =====
`timescale 1ns / 1ps
module nlp_int_scan
    import nlp_pkg::*;
#(
    parameter int RANGE_WIDTH = NLP_RANGE_WIDTH,
    parameter bit IS_HEX      = 1'b0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_feed,
    input  logic       i_clear,
    input  logic [7:0] i_char,
    output t_int_res   o_res
);

    localparam int EW = RANGE_WIDTH + 5;

    localparam logic [2:0] PH_WS      = 3'd0;
    localparam logic [2:0] PH_SIGNED  = 3'd1;
    localparam logic [2:0] PH_ZERO    = 3'd2;
    localparam logic [2:0] PH_AFTER_X = 3'd3;
    localparam logic [2:0] PH_DIGITS  = 3'd4;
    localparam logic [2:0] PH_STOP    = 3'd5;

    logic [2:0]             r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [RANGE_WIDTH-1:0] r_mag, n_mag;
    logic                   r_digit, n_digit;
    logic                   r_over, n_over;

    logic       w_space, w_sign, w_dec, w_hex_letter, w_x;
    logic [3:0] w_dval;
    logic       w_take;
    logic [3:0] w_d;
    logic [2:0] w_phase_eff;
    logic [EW-1:0] w_mag_ext, w_cand, w_lim;

    // Classify the character
    assign w_space      = (i_char == CH_SPACE) || (i_char >= CH_TAB && i_char <= CH_CR);
    assign w_sign       = (i_char == CH_PLUS) || (i_char == CH_MINUS);
    assign w_dec        = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_hex_letter = (i_char >= CH_A_UP && i_char <= CH_F_UP) ||
                          (i_char >= CH_A_LO && i_char <= CH_F_LO);
    assign w_x          = (i_char == CH_X_UP) || (i_char == CH_X_LO);
    assign w_dval       = w_dec ? i_char[3:0] : 4'(i_char[3:0] + 4'd9);

    // Candidate magnitude and the signed limit
    assign w_mag_ext = {5'b0, r_mag};
    assign w_cand    = (IS_HEX ? (w_mag_ext << 4) : ((w_mag_ext << 3) + (w_mag_ext << 1)))
                       + {{(EW-4){1'b0}}, w_d};
    assign w_lim     = {{(EW-RANGE_WIDTH+1){1'b0}}, {(RANGE_WIDTH-1){1'b1}}}
                       + {{(EW-1){1'b0}}, r_neg};

    // Advance the scanner by one character
    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_digit     = r_digit;
        n_over      = r_over;
        n_mag       = r_mag;
        w_take      = 1'b0;
        w_d         = 4'd0;
        w_phase_eff = r_phase;
        if (i_feed && r_phase != PH_STOP) begin
            if (r_phase == PH_WS && w_space) begin
                n_phase = r_phase;
            end else if (r_phase == PH_WS && w_sign) begin
                n_neg   = (i_char == CH_MINUS);
                n_phase = PH_SIGNED;
            end else if (!IS_HEX) begin
                if (w_dec) begin
                    w_take  = 1'b1;
                    w_d     = w_dval;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_STOP;
                end
            end else begin
                if (r_phase == PH_WS) begin
                    w_phase_eff = PH_SIGNED;
                end
                if (w_phase_eff == PH_SIGNED && i_char == CH_ZERO) begin
                    w_take  = 1'b1;
                    n_phase = PH_ZERO;
                end else if (w_phase_eff == PH_ZERO && w_x) begin
                    n_phase = PH_AFTER_X;
                end else if (w_dec || w_hex_letter) begin
                    w_take  = 1'b1;
                    w_d     = w_dval;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_STOP;
                end
            end
        end
        // Accumulate, freeze once past the limit
        if (w_take) begin
            n_digit = 1'b1;
            if (!r_over) begin
                if (w_cand > w_lim) begin
                    n_over = 1'b1;
                end else begin
                    n_mag = w_cand[RANGE_WIDTH-1:0];
                end
            end
        end
    end

    // Hold state, drop it at the end of a token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_WS;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_digit <= 1'b0;
            r_over  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_digit <= n_digit;
            r_over  <= n_over;
        end
    end

    assign o_res.digit = n_digit;
    assign o_res.over  = n_over;
    assign o_res.value = n_neg ? 16'(16'd0 - n_mag[15:0]) : n_mag[15:0];

    a_over_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over |-> r_digit)
        else $error("overflow flagged without a digit");

    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_phase == PH_WS) && !r_digit && !r_over && (r_mag == '0))
        else $error("scanner not restarted after token end");

endmodule

// ===== design/numeric_literal_parser_16bit_top.sv =====
`timescale 1ns / 1ps
// Flow: a character accepted into the input register is processed from there; its result,
// if it ends a token, is captured in the result register.
// Throughput: one character per cycle, set by the single-pass accumulator update
// between the input and result registers, unless a token end waits on an untaken result.
// Reset: synchronous, active low; clears the token state and both valid flags at once.
module numeric_literal_parser_16bit_top
    import nlp_pkg::*;
#(
    parameter int RANGE_WIDTH   = NLP_RANGE_WIDTH,
    parameter int BINARY_DIGITS = NLP_BINARY_DIGITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    nlp_char_if.sink        i_in,
    nlp_res_if.source       o_out
);

    localparam int COUNT_SAT = BINARY_DIGITS + 15;
    localparam int CNT_W     = $clog2(COUNT_SAT + 1);
    localparam int BIN_LEN   = BINARY_DIGITS + 2;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_in_empty;

    logic w_out_free, w_ends, w_process, w_feed_dec, w_feed_hex, w_feed_bin, w_clear;

    // Token state
    logic [CNT_W-1:0]         r_count, n_count;
    logic [7:0]               r_c0, r_c1, r_c2, n_c0, n_c1, n_c2;
    logic [BINARY_DIGITS-1:0] r_bin, n_bin;
    logic                     r_bin_bad, n_bin_bad;

    t_int_res w_dec_res, w_hex_res;

    logic [15:0] w_value, w_bin16;
    t_status     w_status;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_value;
    t_status     r_out_status;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_ends     = r_in_empty || r_in_last;
    assign w_process  = r_in_valid && (w_out_free || !w_ends);
    assign i_in.ready = !r_in_valid || w_process;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_char  <= i_in.char_code;
            r_in_last  <= i_in.last_char;
            r_in_empty <= i_in.empty_token;
        end
    end

    assign w_feed_dec = w_process && !r_in_empty;
    assign w_feed_hex = w_feed_dec && (r_count >= CNT_W'(2));
    assign w_feed_bin = w_feed_hex && (r_count < CNT_W'(BIN_LEN));
    assign w_clear    = w_process && w_ends;

    nlp_int_scan #(.RANGE_WIDTH(RANGE_WIDTH), .IS_HEX(1'b0)) u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (w_feed_dec),
        .i_clear (w_clear),
        .i_char  (r_in_char),
        .o_res   (w_dec_res)
    );

    nlp_int_scan #(.RANGE_WIDTH(RANGE_WIDTH), .IS_HEX(1'b1)) u_hex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (w_feed_hex),
        .i_clear (w_clear),
        .i_char  (r_in_char),
        .o_res   (w_hex_res)
    );

    // Count characters, keep the first three, shift in binary digits
    always_comb begin
        n_count   = r_count;
        n_c0      = r_c0;
        n_c1      = r_c1;
        n_c2      = r_c2;
        n_bin     = r_bin;
        n_bin_bad = r_bin_bad;
        if (w_feed_dec) begin
            if (r_count == CNT_W'(0)) n_c0 = r_in_char;
            if (r_count == CNT_W'(1)) n_c1 = r_in_char;
            if (r_count == CNT_W'(2)) n_c2 = r_in_char;
            if (r_count < CNT_W'(COUNT_SAT)) n_count = CNT_W'(r_count + 1'b1);
        end
        if (w_feed_bin) begin
            if (r_in_char == CH_ZERO || r_in_char == CH_ONE) begin
                n_bin = (r_bin << 1) | BINARY_DIGITS'(r_in_char[0]);
            end else begin
                n_bin_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_count   <= '0;
            r_c0      <= 8'd0;
            r_c1      <= 8'd0;
            r_c2      <= 8'd0;
            r_bin     <= '0;
            r_bin_bad <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_c0      <= n_c0;
            r_c1      <= n_c1;
            r_c2      <= n_c2;
            r_bin     <= n_bin;
            r_bin_bad <= n_bin_bad;
        end
    end

    assign w_bin16 = 16'({16'd0, n_bin});

    // Pick the token format and form the result
    always_comb begin
        w_value  = 16'd0;
        w_status = ST_OK;
        if (r_in_empty) begin
            w_status = ST_EMPTY;
        end else if (n_count == CNT_W'(3) && n_c0 == CH_QUOTE && n_c2 == CH_QUOTE) begin
            w_value = {{8{n_c1[7]}}, n_c1};
        end else if (n_count >= CNT_W'(3) && n_c0 == CH_ZERO &&
                     (n_c1 == CH_X_UP || n_c1 == CH_X_LO)) begin
            if (!w_hex_res.digit)     w_status = ST_NO_DIGITS;
            else if (w_hex_res.over)  w_status = ST_RANGE;
            else                      w_value  = w_hex_res.value;
        end else if (n_count >= CNT_W'(3) && n_c0 == CH_ZERO &&
                     (n_c1 == CH_B_UP || n_c1 == CH_B_LO)) begin
            if (n_count != CNT_W'(BIN_LEN)) w_status = ST_BIN_LENGTH;
            else if (n_bin_bad)             w_status = ST_BIN_DIGIT;
            else                            w_value  = w_bin16;
        end else begin
            if (!w_dec_res.digit)     w_status = ST_NO_DIGITS;
            else if (w_dec_res.over)  w_status = ST_RANGE;
            else                      w_value  = w_dec_res.value;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_clear) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_out_value  <= w_value;
            r_out_status <= w_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_process && r_in_empty) |=> r_out_valid && (r_out_status == ST_EMPTY))
        else $error("empty token did not report empty status");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_value == 16'd0))
        else $error("error result carries a nonzero value");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status <= ST_BIN_DIGIT))
        else $error("status code out of range");

    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_count == '0) && !r_bin_bad)
        else $error("token state not cleared after result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_clear)
        else $error("pending result overwritten");

endmodule
